FILE: hw/rtl/assert_macros.svh
// Assertion macros, included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DWS_ASSERT(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
    else $error("assertion failed");
`define DWS_ASSERT_NR(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) else $error("assertion failed");
`else
`define DWS_ASSERT(lbl, clk_s, rstn_s, prop)
`define DWS_ASSERT_NR(lbl, clk_s, prop)
`endif
`endif

FILE: hw/rtl/dws_pkg.sv
// Types, constants and fixed-point helpers of the wave plate stepper.
package dws_pkg;
  localparam int GRID        = 256;
  localparam int GRID_BITS   = $clog2(GRID);
  localparam int GU_W        = GRID_BITS + 1;
  localparam int LAYER_BITS  = 2;
  localparam int LAYERS      = 3;
  localparam int MEM_DEPTH   = LAYERS * GRID * GRID;
  localparam int ADDR_W      = LAYER_BITS + 2 * GRID_BITS;
  localparam int FRAC_BITS   = 28;
  localparam int VAL_W       = 32;
  localparam int COEF_W      = 29;
  localparam int LAP_W       = 36;
  localparam int HALF_W      = LAP_W / 2;
  localparam int PROD_W      = 66;
  localparam int RND_W       = PROD_W - FRAC_BITS;
  localparam int NUM_W       = 40;
  localparam int NUM_SAT_W   = 36;
  localparam int CNT_W       = 32;
  localparam int IDX_W       = 3;

  localparam logic [COEF_W-1:0] COEF_MAX = COEF_W'(1) << FRAC_BITS;
  localparam logic signed [NUM_W-1:0] NUM_LIMIT = NUM_W'(1) <<< (FRAC_BITS + 6);

  typedef enum logic [IDX_W-1:0] {
    REG_GAMMA = 3'd0,
    REG_DAMP  = 3'd1,
    REG_INV   = 3'd2,
    REG_GRID  = 3'd3,
    REG_DROW  = 3'd4,
    REG_DCOL  = 3'd5
  } reg_idx_t;

  localparam logic CMD_STEP = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_RDCELL, ST_RDWAIT, ST_FETCH, ST_M1, ST_W1,
    ST_M2, ST_W2, ST_M3, ST_W3, ST_WRITE, ST_DONE
  } state_t;

  typedef struct packed {
    logic [COEF_W-1:0]    gamma_sq;
    logic [COEF_W-1:0]    damping;
    logic [COEF_W-1:0]    inv_denom;
    logic [GU_W-1:0]      grid_used;
    logic [GRID_BITS-1:0] drive_row;
    logic [GRID_BITS-1:0] drive_col;
  } cfg_t;

  function automatic logic [ADDR_W-1:0] mem_addr(input logic [LAYER_BITS-1:0] layer,
                                                 input logic [GRID_BITS-1:0] r,
                                                 input logic [GRID_BITS-1:0] c);
    mem_addr = {layer, r, c};
  endfunction

  function automatic logic signed [RND_W-1:0] fx_round(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p + (PROD_W'(1) <<< (FRAC_BITS - 1));
    fx_round = RND_W'(t >>> FRAC_BITS);
  endfunction

  function automatic logic signed [NUM_SAT_W-1:0] sat_num(input logic signed [NUM_W-1:0] x);
    logic signed [NUM_W-1:0] y;
    if (x > NUM_LIMIT) y = NUM_LIMIT;
    else if (x < -NUM_LIMIT) y = -NUM_LIMIT;
    else y = x;
    sat_num = NUM_SAT_W'(y);
  endfunction

  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [RND_W-1:0] x);
    logic signed [RND_W-1:0] hi;
    logic signed [RND_W-1:0] lo;
    hi = RND_W'(33'sh0_7FFF_FFFF);
    lo = -hi - RND_W'(1);
    if (x > hi) sat_val = {1'b0, {(VAL_W-1){1'b1}}};
    else if (x < lo) sat_val = {1'b1, {(VAL_W-1){1'b0}}};
    else sat_val = VAL_W'(x);
  endfunction
endpackage

FILE: hw/rtl/dws_if.sv
// Request, result and register write channel interfaces.
interface dws_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   command;
  logic [dws_pkg::GRID_BITS-1:0]          row;
  logic [dws_pkg::GRID_BITS-1:0]          col;
  logic signed [dws_pkg::VAL_W-1:0]       drive;
  modport source (output valid, command, row, col, drive, input ready);
  modport sink (input valid, command, row, col, drive, output ready);
endinterface

interface dws_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [dws_pkg::VAL_W-1:0]       value;
  logic [dws_pkg::CNT_W-1:0]              step_count;
  modport source (output valid, value, step_count, input ready);
  modport sink (input valid, value, step_count, output ready);
endinterface

interface dws_cfg_if;
  logic                                   valid;
  logic                                   ready;
  logic [dws_pkg::IDX_W-1:0]              index;
  logic [dws_pkg::VAL_W-1:0]              data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/dws_ram.sv
// Generic single-clock RAM, one write and one registered read port.
module dws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

FILE: hw/rtl/dws_mul.sv
// Shared multi-cycle coefficient by sample multiplier, two partial products.
module dws_mul (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic [dws_pkg::COEF_W-1:0]           a,
  input  logic signed [dws_pkg::LAP_W-1:0]     b,
  output logic                                 done,
  output logic signed [dws_pkg::PROD_W-1:0]    p
);
  localparam int H = dws_pkg::HALF_W;
  localparam int CW = dws_pkg::COEF_W;

  logic [1:0]                          ph_r;
  logic                                done_r;
  logic [CW-1:0]                       a_r;
  logic signed [dws_pkg::LAP_W-1:0]    b_r;
  logic [CW+H-1:0]                     lo_r;
  logic signed [dws_pkg::PROD_W-1:0]   p_r;
  logic signed [CW+H:0]                hi_w;

  assign hi_w = $signed({1'b0, a_r}) * $signed(b_r[dws_pkg::LAP_W-1:H]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= 2'd0;
      done_r <= 1'b0;
    end else begin
      done_r <= (ph_r == 2'd2);
      if (start) begin
        ph_r <= 2'd1;
      end else if (ph_r == 2'd1) begin
        ph_r <= 2'd2;
      end else begin
        ph_r <= 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
    end
    if (ph_r == 2'd1) begin
      lo_r <= a_r * b_r[H-1:0];
    end
    if (ph_r == 2'd2) begin
      p_r <= (dws_pkg::PROD_W'(hi_w) <<< H) + $signed(dws_pkg::PROD_W'(lo_r));
    end
  end

  assign done = done_r;
  assign p    = p_r;
endmodule

FILE: hw/rtl/dws_regs.sv
// Configuration registers with range limiting on write.
module dws_regs (
  input  logic               clk,
  input  logic               rst_n,
  dws_cfg_if.sink            cfg_ch,
  output dws_pkg::cfg_t      cfg
);
  dws_pkg::cfg_t             cfg_r;
  logic [dws_pkg::COEF_W-1:0] coef_w;
  logic [dws_pkg::GU_W-1:0]   gu_w;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    coef_w = cfg_ch.data[dws_pkg::COEF_W-1:0];
    if (coef_w > dws_pkg::COEF_MAX) coef_w = dws_pkg::COEF_MAX;
    gu_w = cfg_ch.data[dws_pkg::GU_W-1:0];
    if (gu_w < dws_pkg::GU_W'(3)) gu_w = dws_pkg::GU_W'(3);
    if (gu_w > dws_pkg::GU_W'(dws_pkg::GRID)) gu_w = dws_pkg::GU_W'(dws_pkg::GRID);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gamma_sq  <= dws_pkg::COEF_W'(429497);
      cfg_r.damping   <= dws_pkg::COEF_W'(429);
      cfg_r.inv_denom <= dws_pkg::COEF_W'(268435026);
      cfg_r.grid_used <= dws_pkg::GU_W'(dws_pkg::GRID);
      cfg_r.drive_row <= dws_pkg::GRID_BITS'(127);
      cfg_r.drive_col <= dws_pkg::GRID_BITS'(127);
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        dws_pkg::REG_GAMMA: cfg_r.gamma_sq  <= coef_w;
        dws_pkg::REG_DAMP:  cfg_r.damping   <= coef_w;
        dws_pkg::REG_INV:   cfg_r.inv_denom <= coef_w;
        dws_pkg::REG_GRID:  cfg_r.grid_used <= gu_w;
        dws_pkg::REG_DROW:  cfg_r.drive_row <= cfg_ch.data[dws_pkg::GRID_BITS-1:0];
        dws_pkg::REG_DCOL:  cfg_r.drive_col <= cfg_ch.data[dws_pkg::GRID_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;
endmodule

FILE: hw/rtl/damped_wave_2d_stencil_step.sv
// Top level: layer sequencer, stencil datapath and result register.
//  channel  dir  handshake        payload
//  in_ch    in   valid/ready      command, row, col, drive
//  out_ch   out  valid/ready      value, step_count
//  cfg_ch   in   valid/ready      index, data (always ready)
// A step visits each interior cell of side n in turn; each cell costs six
// reads and up to nine writes on the one field memory port pair plus three
// passes through the shared multiplier.
// After reset a clearing pass zeroes all 196608 memory words; no request
// is taken then. A result waiting in the output register stalls completion.
`include "assert_macros.svh"
module damped_wave_2d_stencil_step (
  input  logic      clk,
  input  logic      rst_n,
  dws_in_if.sink    in_ch,
  dws_out_if.source out_ch,
  dws_cfg_if.sink   cfg_ch
);
  localparam int GB = dws_pkg::GRID_BITS;
  localparam int LB = dws_pkg::LAYER_BITS;

  dws_pkg::cfg_t   cfg;
  dws_pkg::state_t state_r, state_nxt;

  logic [dws_pkg::ADDR_W-1:0]          clr_r;
  logic [LB-1:0]                       newest_r, cur_w, old_w, nxt_w;
  logic [dws_pkg::CNT_W-1:0]           steps_r;
  logic [GB-1:0]                       r_r, c_r;
  logic signed [dws_pkg::VAL_W-1:0]    drv_r;
  logic [2:0]                          fcnt_r;
  logic [1:0]                          wi_r, wj_r;
  logic signed [dws_pkg::VAL_W-1:0]    uc_r, uo_r, res_r;
  logic signed [dws_pkg::LAP_W-1:0]    nsum_r, lap_w;
  logic signed [dws_pkg::RND_W-1:0]    t1_r;
  logic signed [dws_pkg::NUM_SAT_W-1:0] num_r;
  logic signed [dws_pkg::NUM_W-1:0]    num_w;
  logic                                out_valid_r;
  logic signed [dws_pkg::VAL_W-1:0]    out_value_r;
  logic [dws_pkg::CNT_W-1:0]           out_cnt_r;

  logic                                mem_we, mem_re;
  logic [dws_pkg::ADDR_W-1:0]          mem_waddr, mem_raddr;
  logic [dws_pkg::VAL_W-1:0]           mem_wdata, mem_rdata;
  logic                                mul_start, mul_done;
  logic [dws_pkg::COEF_W-1:0]          mul_a;
  logic signed [dws_pkg::LAP_W-1:0]    mul_b;
  logic signed [dws_pkg::PROD_W-1:0]   mul_p;

  logic [GB-1:0]                       nm1_w, nm2_w, wr_row, wr_col;
  logic                                row_ok, col_ok, last_c, last_r, wr_last;
  logic                                rd_in_range, out_load, drive_hit;

  dws_regs u_regs (.clk(clk), .rst_n(rst_n), .cfg_ch(cfg_ch), .cfg(cfg));

  dws_ram #(.WIDTH(dws_pkg::VAL_W), .DEPTH(dws_pkg::MEM_DEPTH)) u_ram (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .re(mem_re), .raddr(mem_raddr), .rdata(mem_rdata)
  );

  dws_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .p(mul_p)
  );

  assign cur_w = newest_r;
  assign old_w = (newest_r == LB'(0)) ? LB'(2) : newest_r - LB'(1);
  assign nxt_w = (newest_r == LB'(2)) ? LB'(0) : newest_r + LB'(1);
  assign nm1_w = GB'(cfg.grid_used - dws_pkg::GU_W'(1));
  assign nm2_w = GB'(cfg.grid_used - dws_pkg::GU_W'(2));
  assign last_c = (c_r == nm2_w);
  assign last_r = (r_r == nm2_w);
  assign wr_last = (wi_r == 2'd2) && (wj_r == 2'd2);
  assign rd_in_range = ({1'b0, r_r} < cfg.grid_used) && ({1'b0, c_r} < cfg.grid_used);
  assign drive_hit = (r_r == cfg.drive_row) && (c_r == cfg.drive_col);
  assign lap_w = nsum_r - (dws_pkg::LAP_W'(uc_r) <<< 2);
  assign out_load = (state_r == dws_pkg::ST_DONE) && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = (state_r == dws_pkg::ST_IDLE);

  assign num_w = (dws_pkg::NUM_W'(uc_r) <<< 1) - dws_pkg::NUM_W'(uo_r)
               + dws_pkg::NUM_W'(t1_r) + dws_pkg::NUM_W'(dws_pkg::fx_round(mul_p))
               + (drive_hit ? dws_pkg::NUM_W'(drv_r) : dws_pkg::NUM_W'(0));

  always_comb begin
    unique case (wi_r)
      2'd0:    begin wr_row = r_r;      row_ok = 1'b1; end
      2'd1:    begin wr_row = GB'(0);   row_ok = (r_r == GB'(1)); end
      2'd2:    begin wr_row = nm1_w;    row_ok = last_r; end
      default: begin wr_row = r_r;      row_ok = 1'b0; end
    endcase
    unique case (wj_r)
      2'd0:    begin wr_col = c_r;      col_ok = 1'b1; end
      2'd1:    begin wr_col = GB'(0);   col_ok = (c_r == GB'(1)); end
      2'd2:    begin wr_col = nm1_w;    col_ok = last_c; end
      default: begin wr_col = c_r;      col_ok = 1'b0; end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dws_pkg::ST_CLEAR:
        if (clr_r == dws_pkg::ADDR_W'(dws_pkg::MEM_DEPTH - 1)) state_nxt = dws_pkg::ST_IDLE;
      dws_pkg::ST_IDLE:
        if (in_ch.valid) begin
          state_nxt = (in_ch.command == dws_pkg::CMD_READ) ? dws_pkg::ST_RDCELL
                                                           : dws_pkg::ST_FETCH;
        end
      dws_pkg::ST_RDCELL: state_nxt = rd_in_range ? dws_pkg::ST_RDWAIT : dws_pkg::ST_DONE;
      dws_pkg::ST_RDWAIT: state_nxt = dws_pkg::ST_DONE;
      dws_pkg::ST_FETCH:  if (fcnt_r == 3'd6) state_nxt = dws_pkg::ST_M1;
      dws_pkg::ST_M1:     state_nxt = dws_pkg::ST_W1;
      dws_pkg::ST_W1:     if (mul_done) state_nxt = dws_pkg::ST_M2;
      dws_pkg::ST_M2:     state_nxt = dws_pkg::ST_W2;
      dws_pkg::ST_W2:     if (mul_done) state_nxt = dws_pkg::ST_M3;
      dws_pkg::ST_M3:     state_nxt = dws_pkg::ST_W3;
      dws_pkg::ST_W3:     if (mul_done) state_nxt = dws_pkg::ST_WRITE;
      dws_pkg::ST_WRITE:
        if (wr_last) state_nxt = (last_c && last_r) ? dws_pkg::ST_DONE : dws_pkg::ST_FETCH;
      dws_pkg::ST_DONE:   if (out_load) state_nxt = dws_pkg::ST_IDLE;
      default:            state_nxt = dws_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_r;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = dws_pkg::mem_addr(cur_w, r_r, c_r);
    mul_start = 1'b0;
    mul_a     = cfg.gamma_sq;
    mul_b     = lap_w;
    unique case (state_r)
      dws_pkg::ST_CLEAR: mem_we = 1'b1;
      dws_pkg::ST_RDCELL: mem_re = rd_in_range;
      dws_pkg::ST_FETCH: begin
        mem_re = (fcnt_r != 3'd6);
        unique case (fcnt_r)
          3'd1:    mem_raddr = dws_pkg::mem_addr(cur_w, r_r + GB'(1), c_r);
          3'd2:    mem_raddr = dws_pkg::mem_addr(cur_w, r_r - GB'(1), c_r);
          3'd3:    mem_raddr = dws_pkg::mem_addr(cur_w, r_r, c_r + GB'(1));
          3'd4:    mem_raddr = dws_pkg::mem_addr(cur_w, r_r, c_r - GB'(1));
          3'd5:    mem_raddr = dws_pkg::mem_addr(old_w, r_r, c_r);
          default: mem_raddr = dws_pkg::mem_addr(cur_w, r_r, c_r);
        endcase
      end
      dws_pkg::ST_M1: mul_start = 1'b1;
      dws_pkg::ST_M2: begin
        mul_start = 1'b1;
        mul_a     = cfg.damping;
        mul_b     = dws_pkg::LAP_W'(uo_r);
      end
      dws_pkg::ST_M3: begin
        mul_start = 1'b1;
        mul_a     = cfg.inv_denom;
        mul_b     = num_r;
      end
      dws_pkg::ST_WRITE: begin
        mem_we    = row_ok && col_ok;
        mem_waddr = dws_pkg::mem_addr(nxt_w, wr_row, wr_col);
        mem_wdata = res_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dws_pkg::ST_CLEAR;
      clr_r       <= '0;
      newest_r    <= '0;
      steps_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == dws_pkg::ST_CLEAR) clr_r <= clr_r + dws_pkg::ADDR_W'(1);
      if (state_r == dws_pkg::ST_WRITE && wr_last && last_c && last_r) begin
        newest_r <= nxt_w;
        steps_r  <= steps_r + dws_pkg::CNT_W'(1);
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      dws_pkg::ST_IDLE: begin
        fcnt_r <= 3'd0;
        wi_r   <= 2'd0;
        wj_r   <= 2'd0;
        drv_r  <= in_ch.drive;
        res_r  <= '0;
        if (in_ch.command == dws_pkg::CMD_READ) begin
          r_r <= in_ch.row;
          c_r <= in_ch.col;
        end else begin
          r_r <= GB'(1);
          c_r <= GB'(1);
        end
      end
      dws_pkg::ST_RDWAIT: res_r <= mem_rdata;
      dws_pkg::ST_FETCH: begin
        fcnt_r <= (fcnt_r == 3'd6) ? 3'd0 : fcnt_r + 3'd1;
        unique case (fcnt_r)
          3'd0:    nsum_r <= '0;
          3'd1:    uc_r   <= mem_rdata;
          3'd6:    uo_r   <= mem_rdata;
          default: nsum_r <= nsum_r + dws_pkg::LAP_W'($signed(mem_rdata));
        endcase
      end
      dws_pkg::ST_W1: if (mul_done) t1_r <= dws_pkg::fx_round(mul_p);
      dws_pkg::ST_W2: if (mul_done) num_r <= dws_pkg::sat_num(num_w);
      dws_pkg::ST_W3: if (mul_done) res_r <= dws_pkg::sat_val(dws_pkg::fx_round(mul_p));
      dws_pkg::ST_WRITE: begin
        if (wj_r == 2'd2) begin
          wj_r <= 2'd0;
          wi_r <= (wi_r == 2'd2) ? 2'd0 : wi_r + 2'd1;
        end else begin
          wj_r <= wj_r + 2'd1;
        end
        if (wr_last) begin
          if (last_c && last_r) begin
            res_r <= '0;
          end else if (last_c) begin
            c_r <= GB'(1);
            r_r <= r_r + GB'(1);
          end else begin
            c_r <= c_r + GB'(1);
          end
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_value_r <= res_r;
      out_cnt_r   <= steps_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.value      = out_value_r;
  assign out_ch.step_count = out_cnt_r;

  `DWS_ASSERT_NR(a_reset_clear, clk, !rst_n |=> state_r == dws_pkg::ST_CLEAR)
  `DWS_ASSERT(a_no_req_clear, clk, rst_n, (state_r == dws_pkg::ST_CLEAR) |-> !in_ch.ready)
  `DWS_ASSERT(a_we_phase, clk, rst_n, mem_we |-> (state_r == dws_pkg::ST_WRITE || state_r == dws_pkg::ST_CLEAR))
  `DWS_ASSERT(a_mul_wait, clk, rst_n, mul_done |-> (state_r == dws_pkg::ST_W1 || state_r == dws_pkg::ST_W2 || state_r == dws_pkg::ST_W3))
  `DWS_ASSERT(a_steps_only_end, clk, rst_n, !$stable(steps_r) |-> $past(state_r) == dws_pkg::ST_WRITE)
endmodule
